@@ design/cubic_bezier_offset_points_unit_defines.svh @@
// ----------------------------------------------------------------------------
// cubic_bezier_offset_points_unit_defines.svh
// Assertion macros used by the checker of the Bezier offset point unit.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_OFFSET_POINTS_UNIT_DEFINES_SVH
`define CUBIC_BEZIER_OFFSET_POINTS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CBOP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CBOP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/cbop_pkg.sv @@
// ----------------------------------------------------------------------------
// cbop_pkg
// Types and constants shared by the Bezier offset point unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbop_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_DISTANCE = 1'd1;

  localparam logic [5:0]  SEG_COUNT_RESET = 6'd32;
  localparam logic [30:0] OFFSET_RESET    = 31'd65536;

  // One curve point as issued by the sequencer.
  typedef struct packed {
    logic [5:0]       idx;
    logic [5:0]       u;
    logic [5:0]       n;
    logic             last;
    logic [3:0][31:0] px;
    logic [3:0][31:0] py;
  } pt_t;

endpackage

`default_nettype wire

@@ design/cubic_bezier_offset_points_unit.sv @@
// The first point is issued through the sequencer's busy flag and point register
// after the curve beat is taken. The curve and offset dividers and the 32-stage
// square root set the depth. Throughput: one result beat per cycle within a
// curve unless a result beat is held; the input stays stalled while a curve's
// points are issued. Reset (synchronous, active low) empties the pipeline and
// restores the segment count to 32 and the offset distance to 1.0.
// ----------------------------------------------------------------------------
// cubic_bezier_offset_points_unit
// Evaluates a cubic Bezier at t = i/N with offset points along the normal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_offset_points_unit #(
  parameter int MAX_POINTS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [cbop_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbop_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [31:0]                 in_ctrl0_x,
  input  logic signed [31:0]                 in_ctrl0_y,
  input  logic signed [31:0]                 in_ctrl1_x,
  input  logic signed [31:0]                 in_ctrl1_y,
  input  logic signed [31:0]                 in_ctrl2_x,
  input  logic signed [31:0]                 in_ctrl2_y,
  input  logic signed [31:0]                 in_ctrl3_x,
  input  logic signed [31:0]                 in_ctrl3_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [5:0]                         out_point_index,
  output logic signed [31:0]                 out_center_x,
  output logic signed [31:0]                 out_center_y,
  output logic signed [31:0]                 out_left_x,
  output logic signed [31:0]                 out_left_y,
  output logic signed [31:0]                 out_right_x,
  output logic signed [31:0]                 out_right_y,
  output logic                               out_flat_tangent,
  output logic                               out_last
);
  import cbop_pkg::*;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               sx;
    logic               sy;
    logic               flat;
    logic [5:0]         idx;
    logic               last;
  } tail_t;

  typedef struct packed {
    logic [47:0] ax;
    logic [47:0] ay;
    logic        sx;
    logic        sy;
    logic        flat;
    logic [5:0]  idx;
    logic        last;
    logic        sgx;
  } csb_t;

  typedef struct packed {
    tail_t       t;
    logic [47:0] ax;
    logic [47:0] ay;
  } nrm_t;

  typedef struct packed {
    logic [61:0] dax;
    logic [61:0] day;
    tail_t       t;
  } ssb_t;

  function automatic logic signed [34:0] sx35(input logic [31:0] v);
    return {{3{v[31]}}, v};
  endfunction

  function automatic logic [31:0] sat33(input logic [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  // Configuration registers
  logic [5:0]  seg_r;
  logic [30:0] dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r  <= SEG_COUNT_RESET;
      dist_r <= OFFSET_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SEGMENT_COUNT:   seg_r  <= cfg_wdata[5:0];
        REG_OFFSET_DISTANCE: dist_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together unless the output beat is held.
  logic adv;
  logic out_valid_r;
  assign adv = !out_valid_r || !out_stall;

  logic             pt_valid;
  pt_t              pt;
  logic [3:0][31:0] in_px;
  logic [3:0][31:0] in_py;

  assign in_px = {in_ctrl3_x, in_ctrl2_x, in_ctrl1_x, in_ctrl0_x};
  assign in_py = {in_ctrl3_y, in_ctrl2_y, in_ctrl1_y, in_ctrl0_y};

  cbop_seq #(.MAX_POINTS(MAX_POINTS)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_px     (in_px),
    .in_py     (in_py),
    .seg_count (seg_r),
    .adv       (adv),
    .pt_valid  (pt_valid),
    .pt        (pt)
  );

  // Stage A: squares of u, i and N, the product of u and i, control differences.
  logic                a_valid_r;
  logic [11:0]         a_uu_r, a_ui_r, a_ii_r, a_nn_r;
  logic [5:0]          a_u_r, a_i_r, a_n_r, a_idx_r;
  logic                a_last_r;
  logic [3:0][31:0]    a_px_r, a_py_r;
  logic signed [34:0]  a_dx_r [3];
  logic signed [34:0]  a_dy_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= pt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_uu_r   <= 12'(pt.u) * 12'(pt.u);
      a_ui_r   <= 12'(pt.u) * 12'(pt.idx);
      a_ii_r   <= 12'(pt.idx) * 12'(pt.idx);
      a_nn_r   <= 12'(pt.n) * 12'(pt.n);
      a_u_r    <= pt.u;
      a_i_r    <= pt.idx;
      a_n_r    <= pt.n;
      a_idx_r  <= pt.idx;
      a_last_r <= pt.last;
      a_px_r   <= pt.px;
      a_py_r   <= pt.py;
      for (int k = 0; k < 3; k++) begin
        a_dx_r[k] <= 35'sd3 * (sx35(pt.px[k+1]) - sx35(pt.px[k]));
        a_dy_r[k] <= 35'sd3 * (sx35(pt.py[k+1]) - sx35(pt.py[k]));
      end
    end
  end

  // Stage B: Bernstein weights scaled by N^3 and tangent weights by N^2.
  logic                b_valid_r;
  logic [19:0]         b_w_r [4];
  logic [12:0]         b_c_r [3];
  logic [17:0]         b_den_r;
  logic [5:0]          b_idx_r;
  logic                b_last_r;
  logic [3:0][31:0]    b_px_r, b_py_r;
  logic signed [34:0]  b_dx_r [3];
  logic signed [34:0]  b_dy_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_w_r[0] <= 20'(a_uu_r) * 20'(a_u_r);
      b_w_r[1] <= 20'd3 * (20'(a_uu_r) * 20'(a_i_r));
      b_w_r[2] <= 20'd3 * (20'(a_ii_r) * 20'(a_u_r));
      b_w_r[3] <= 20'(a_ii_r) * 20'(a_i_r);
      b_c_r[0] <= 13'(a_uu_r);
      b_c_r[1] <= {a_ui_r, 1'b0};
      b_c_r[2] <= 13'(a_ii_r);
      b_den_r  <= 18'(a_nn_r) * 18'(a_n_r);
      b_idx_r  <= a_idx_r;
      b_last_r <= a_last_r;
      b_px_r   <= a_px_r;
      b_py_r   <= a_py_r;
      b_dx_r   <= a_dx_r;
      b_dy_r   <= a_dy_r;
    end
  end

  // Stage C: weighted control points and weighted differences.
  logic                c_valid_r;
  logic signed [52:0]  c_mx_r [4];
  logic signed [52:0]  c_my_r [4];
  logic signed [48:0]  c_tx_r [3];
  logic signed [48:0]  c_ty_r [3];
  logic [17:0]         c_den_r;
  logic [5:0]          c_idx_r;
  logic                c_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (adv) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        c_mx_r[k] <= $signed({1'b0, b_w_r[k]}) * $signed(b_px_r[k]);
        c_my_r[k] <= $signed({1'b0, b_w_r[k]}) * $signed(b_py_r[k]);
      end
      for (int k = 0; k < 3; k++) begin
        c_tx_r[k] <= $signed({1'b0, b_c_r[k]}) * b_dx_r[k];
        c_ty_r[k] <= $signed({1'b0, b_c_r[k]}) * b_dy_r[k];
      end
      c_den_r  <= b_den_r;
      c_idx_r  <= b_idx_r;
      c_last_r <= b_last_r;
    end
  end

  // Stage D: sums.
  logic                d_valid_r;
  logic signed [52:0]  d_nx_r, d_ny_r;
  logic signed [48:0]  d_tx_r, d_ty_r;
  logic [17:0]         d_den_r;
  logic [5:0]          d_idx_r;
  logic                d_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (adv) begin
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_nx_r   <= c_mx_r[0] + c_mx_r[1] + c_mx_r[2] + c_mx_r[3];
      d_ny_r   <= c_my_r[0] + c_my_r[1] + c_my_r[2] + c_my_r[3];
      d_tx_r   <= c_tx_r[0] + c_tx_r[1] + c_tx_r[2];
      d_ty_r   <= c_ty_r[0] + c_ty_r[1] + c_ty_r[2];
      d_den_r  <= c_den_r;
      d_idx_r  <= c_idx_r;
      d_last_r <= c_last_r;
    end
  end

  // Stage E: magnitudes, with half the divisor added for rounding.
  logic        e_valid_r;
  logic [50:0] e_nmx_r, e_nmy_r;
  logic [17:0] e_den_r;
  logic        e_sgy_r;
  csb_t        e_csb_r;
  logic [52:0] e_absx, e_absy;
  logic [48:0] e_abtx, e_abty;

  assign e_absx = d_nx_r[52] ? 53'(-d_nx_r) : 53'(d_nx_r);
  assign e_absy = d_ny_r[52] ? 53'(-d_ny_r) : 53'(d_ny_r);
  assign e_abtx = d_tx_r[48] ? 49'(-d_tx_r) : 49'(d_tx_r);
  assign e_abty = d_ty_r[48] ? 49'(-d_ty_r) : 49'(d_ty_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (adv) begin
      e_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_nmx_r      <= e_absx[50:0] + 51'(d_den_r >> 1);
      e_nmy_r      <= e_absy[50:0] + 51'(d_den_r >> 1);
      e_den_r      <= d_den_r;
      e_sgy_r      <= d_ny_r[52];
      e_csb_r.ax   <= e_abtx[47:0];
      e_csb_r.ay   <= e_abty[47:0];
      e_csb_r.sx   <= d_tx_r[48];
      e_csb_r.sy   <= d_ty_r[48];
      e_csb_r.flat <= (d_tx_r == 49'sd0) && (d_ty_r == 49'sd0);
      e_csb_r.idx  <= d_idx_r;
      e_csb_r.last <= d_last_r;
      e_csb_r.sgx  <= d_nx_r[52];
    end
  end

  // Curve point: rounded division by N^3.
  logic        cdx_valid, cdy_valid;
  logic [31:0] cdx_q, cdy_q;
  csb_t        cdx_sb;
  logic        cdy_sgy;

  cbop_div #(.NUM_W(51), .DEN_W(18), .Q_W(32), .SB_W($bits(csb_t))) u_cdiv_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (e_valid_r),
    .in_num    (e_nmx_r),
    .in_den    (e_den_r),
    .in_sb     (e_csb_r),
    .out_valid (cdx_valid),
    .out_q     (cdx_q),
    .out_sb    (cdx_sb)
  );

  cbop_div #(.NUM_W(51), .DEN_W(18), .Q_W(32), .SB_W(1)) u_cdiv_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (e_valid_r),
    .in_num    (e_nmy_r),
    .in_den    (e_den_r),
    .in_sb     (e_sgy_r),
    .out_valid (cdy_valid),
    .out_q     (cdy_q),
    .out_sb    (cdy_sgy)
  );

  // Normalisation over three stages: the larger tangent magnitude is moved
  // to bit 47, and bits 47:17 then hold it in [2^30, 2^31).
  logic n1_valid_r, n2_valid_r, n3_valid_r;
  nrm_t n1_r, n2_r, n3_r;
  nrm_t n1_nxt, n2_nxt, n3_nxt;

  always_comb begin
    logic [47:0] m;
    n1_nxt.t.cx   = cdx_sb.sgx ? (32'sd0 - $signed(cdx_q)) : $signed(cdx_q);
    n1_nxt.t.cy   = cdy_sgy ? (32'sd0 - $signed(cdy_q)) : $signed(cdy_q);
    n1_nxt.t.sx   = cdx_sb.sx;
    n1_nxt.t.sy   = cdx_sb.sy;
    n1_nxt.t.flat = cdx_sb.flat;
    n1_nxt.t.idx  = cdx_sb.idx;
    n1_nxt.t.last = cdx_sb.last;
    n1_nxt.ax     = cdx_sb.ax;
    n1_nxt.ay     = cdx_sb.ay;
    m = n1_nxt.ax | n1_nxt.ay;
    if (m[47:16] == 32'd0) begin
      n1_nxt.ax = n1_nxt.ax << 32;
      n1_nxt.ay = n1_nxt.ay << 32;
    end
    m = n1_nxt.ax | n1_nxt.ay;
    if (m[47:32] == 16'd0) begin
      n1_nxt.ax = n1_nxt.ax << 16;
      n1_nxt.ay = n1_nxt.ay << 16;
    end
  end

  always_comb begin
    logic [47:0] m;
    n2_nxt = n1_r;
    m = n2_nxt.ax | n2_nxt.ay;
    if (m[47:40] == 8'd0) begin
      n2_nxt.ax = n2_nxt.ax << 8;
      n2_nxt.ay = n2_nxt.ay << 8;
    end
    m = n2_nxt.ax | n2_nxt.ay;
    if (m[47:44] == 4'd0) begin
      n2_nxt.ax = n2_nxt.ax << 4;
      n2_nxt.ay = n2_nxt.ay << 4;
    end
  end

  always_comb begin
    logic [47:0] m;
    n3_nxt = n2_r;
    m = n3_nxt.ax | n3_nxt.ay;
    if (m[47:46] == 2'd0) begin
      n3_nxt.ax = n3_nxt.ax << 2;
      n3_nxt.ay = n3_nxt.ay << 2;
    end
    m = n3_nxt.ax | n3_nxt.ay;
    if (!m[47]) begin
      n3_nxt.ax = n3_nxt.ax << 1;
      n3_nxt.ay = n3_nxt.ay << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_valid_r <= 1'b0;
      n2_valid_r <= 1'b0;
      n3_valid_r <= 1'b0;
    end else if (adv) begin
      n1_valid_r <= cdx_valid && cdy_valid;
      n2_valid_r <= n1_valid_r;
      n3_valid_r <= n2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n1_r <= n1_nxt;
      n2_r <= n2_nxt;
      n3_r <= n3_nxt;
    end
  end

  // Stage M: squares and distance products; stage S: sum of squares.
  logic        m_valid_r, s_valid_r;
  logic [61:0] m_sqx_r, m_sqy_r, m_dax_r, m_day_r;
  tail_t       m_t_r;
  logic [63:0] s_sum_r;
  ssb_t        s_sb_r;
  logic [30:0] m_axn, m_ayn;

  assign m_axn = n3_r.ax[47:17];
  assign m_ayn = n3_r.ay[47:17];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
    end else if (adv) begin
      m_valid_r <= n3_valid_r;
      s_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_sqx_r    <= 62'(m_axn) * 62'(m_axn);
      m_sqy_r    <= 62'(m_ayn) * 62'(m_ayn);
      m_dax_r    <= 62'(dist_r) * 62'(m_axn);
      m_day_r    <= 62'(dist_r) * 62'(m_ayn);
      m_t_r      <= n3_r.t;
      s_sum_r    <= 64'(m_sqx_r) + 64'(m_sqy_r);
      s_sb_r.dax <= m_dax_r;
      s_sb_r.day <= m_day_r;
      s_sb_r.t   <= m_t_r;
    end
  end

  logic        sq_valid;
  logic [31:0] sq_len;
  ssb_t        sq_sb;

  cbop_isqrt #(.R_W(32), .SB_W($bits(ssb_t))) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s_valid_r),
    .in_val    (s_sum_r),
    .in_sb     (s_sb_r),
    .out_valid (sq_valid),
    .out_root  (sq_len),
    .out_sb    (sq_sb)
  );

  // Stage O: rounding bias for the offset divisions.
  logic        o_valid_r;
  logic [62:0] o_nx_r, o_ny_r;
  logic [31:0] o_len_r;
  tail_t       o_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (adv) begin
      o_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_nx_r  <= 63'(sq_sb.dax) + 63'(sq_len >> 1);
      o_ny_r  <= 63'(sq_sb.day) + 63'(sq_len >> 1);
      o_len_r <= sq_len;
      o_t_r   <= sq_sb.t;
    end
  end

  logic        odx_valid, ody_valid;
  logic [30:0] odx_q, ody_q;
  tail_t       odx_t;
  logic        ody_sy;

  cbop_div #(.NUM_W(63), .DEN_W(32), .Q_W(31), .SB_W($bits(tail_t))) u_odiv_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (o_valid_r),
    .in_num    (o_nx_r),
    .in_den    (o_len_r),
    .in_sb     (o_t_r),
    .out_valid (odx_valid),
    .out_q     (odx_q),
    .out_sb    (odx_t)
  );

  cbop_div #(.NUM_W(63), .DEN_W(32), .Q_W(31), .SB_W(1)) u_odiv_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (o_valid_r),
    .in_num    (o_ny_r),
    .in_den    (o_len_r),
    .in_sb     (o_t_r.sy),
    .out_valid (ody_valid),
    .out_q     (ody_q),
    .out_sb    (ody_sy)
  );

  // Final stage: signed offsets and saturated offset points.
  logic signed [31:0] f_ox, f_oy;
  logic [32:0]        f_cx, f_cy, f_ox33, f_oy33;

  always_comb begin
    f_ox = odx_t.sx ? (32'sd0 - $signed({1'b0, odx_q})) : $signed({1'b0, odx_q});
    f_oy = ody_sy ? (32'sd0 - $signed({1'b0, ody_q})) : $signed({1'b0, ody_q});
    // A zero tangent has no normal: both offset points sit on the curve.
    if (odx_t.flat) begin
      f_ox = 32'sd0;
      f_oy = 32'sd0;
    end
  end

  assign f_cx   = {odx_t.cx[31], odx_t.cx};
  assign f_cy   = {odx_t.cy[31], odx_t.cy};
  assign f_ox33 = {f_ox[31], f_ox};
  assign f_oy33 = {f_oy[31], f_oy};

  logic [5:0]  out_idx_r;
  logic [31:0] out_cx_r, out_cy_r, out_lx_r, out_ly_r, out_rx_r, out_ry_r;
  logic        out_flat_r, out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= odx_valid && ody_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_idx_r  <= odx_t.idx;
      out_cx_r   <= odx_t.cx;
      out_cy_r   <= odx_t.cy;
      out_lx_r   <= sat33(f_cx + f_oy33);
      out_ly_r   <= sat33(f_cy - f_ox33);
      out_rx_r   <= sat33(f_cx - f_oy33);
      out_ry_r   <= sat33(f_cy + f_ox33);
      out_flat_r <= odx_t.flat;
      out_last_r <= odx_t.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_point_index  = out_idx_r;
  assign out_center_x     = out_cx_r;
  assign out_center_y     = out_cy_r;
  assign out_left_x       = out_lx_r;
  assign out_left_y       = out_ly_r;
  assign out_right_x      = out_rx_r;
  assign out_right_y      = out_ry_r;
  assign out_flat_tangent = out_flat_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire

@@ design/cbop_seq.sv @@
// ----------------------------------------------------------------------------
// cbop_seq
// Takes one curve beat and issues its points t = i/N, one per cycle while adv is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbop_seq #(
  parameter int MAX_POINTS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [3:0][31:0] in_px,
  input  logic [3:0][31:0] in_py,
  input  logic [5:0]       seg_count,
  input  logic             adv,
  output logic             pt_valid,
  output cbop_pkg::pt_t    pt
);
  import cbop_pkg::*;

  localparam int         IDX_W = $clog2(MAX_POINTS);
  localparam logic [6:0] MAX_N = 7'(MAX_POINTS - 1);

  logic             busy_r;
  logic [IDX_W-1:0] i_r;
  logic [IDX_W-1:0] n_r;
  logic [3:0][31:0] px_r;
  logic [3:0][31:0] py_r;
  logic             pt_valid_r;
  pt_t              pt_r;
  logic [6:0]       n_sel;
  logic             accept;

  // A count of zero means one segment; too many segments are clamped.
  always_comb begin
    if (seg_count == 6'd0) begin
      n_sel = 7'd1;
    end else if ({1'b0, seg_count} > MAX_N) begin
      n_sel = MAX_N;
    end else begin
      n_sel = {1'b0, seg_count};
    end
  end

  assign accept = in_valid && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      i_r        <= '0;
      pt_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
        i_r    <= '0;
      end else if (busy_r && adv) begin
        if (i_r == n_r) begin
          busy_r <= 1'b0;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
      if (adv) begin
        pt_valid_r <= busy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_px;
      py_r <= in_py;
      n_r  <= n_sel[IDX_W-1:0];
    end
    if (adv) begin
      pt_r.idx  <= 6'(i_r);
      pt_r.u    <= 6'(n_r - i_r);
      pt_r.n    <= 6'(n_r);
      pt_r.last <= (i_r == n_r);
      pt_r.px   <= px_r;
      pt_r.py   <= py_r;
    end
  end

  assign in_stall = busy_r;
  assign pt_valid = pt_valid_r;
  assign pt       = pt_r;

endmodule

`default_nettype wire

@@ design/cbop_div.sv @@
// ----------------------------------------------------------------------------
// cbop_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbop_div #(
  parameter int NUM_W = 51,
  parameter int DEN_W = 18,
  parameter int Q_W   = 32,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [SB_W-1:0]  in_sb,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_q,
  output logic [SB_W-1:0]  out_sb
);

  localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic            v_r   [Q_W];
  logic [W-1:0]    num_r [Q_W];
  logic [W-1:0]    den_r [Q_W];
  logic [Q_W-1:0]  q_r   [Q_W];
  logic [SB_W-1:0] sb_r  [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stg
    localparam int B = Q_W - 1 - s;
    logic            cur_v;
    logic [W-1:0]    cur_num;
    logic [W-1:0]    cur_den;
    logic [Q_W-1:0]  cur_q;
    logic [SB_W-1:0] cur_sb;
    logic [W-1:0]    trial;
    logic            take;

    if (s == 0) begin : g_first
      assign cur_v   = in_valid;
      assign cur_num = W'(in_num);
      assign cur_den = W'(in_den);
      assign cur_q   = '0;
      assign cur_sb  = in_sb;
    end else begin : g_next
      assign cur_v   = v_r[s-1];
      assign cur_num = num_r[s-1];
      assign cur_den = den_r[s-1];
      assign cur_q   = q_r[s-1];
      assign cur_sb  = sb_r[s-1];
    end

    assign trial = cur_den << B;
    assign take  = (cur_num >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[s] <= take ? (cur_num - trial) : cur_num;
        den_r[s] <= cur_den;
        q_r[s]   <= {cur_q[Q_W-2:0], take};
        sb_r[s]  <= cur_sb;
      end
    end
  end

  assign out_valid = v_r[Q_W-1];
  assign out_q     = q_r[Q_W-1];
  assign out_sb    = sb_r[Q_W-1];

endmodule

`default_nettype wire

@@ design/cbop_isqrt.sv @@
// ----------------------------------------------------------------------------
// cbop_isqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbop_isqrt #(
  parameter int R_W  = 32,
  parameter int SB_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [2*R_W-1:0] in_val,
  input  logic [SB_W-1:0]  in_sb,
  output logic             out_valid,
  output logic [R_W-1:0]   out_root,
  output logic [SB_W-1:0]  out_sb
);

  localparam int W = 2 * R_W;

  logic            v_r    [R_W];
  logic [W-1:0]    rem_r  [R_W];
  logic [W-1:0]    root_r [R_W];
  logic [SB_W-1:0] sb_r   [R_W];

  for (genvar s = 0; s < R_W; s++) begin : g_stg
    localparam int           B   = 2 * (R_W - 1 - s);
    localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << B;
    logic            cur_v;
    logic [W-1:0]    cur_rem;
    logic [W-1:0]    cur_root;
    logic [SB_W-1:0] cur_sb;
    logic [W-1:0]    trial;
    logic            take;

    if (s == 0) begin : g_first
      assign cur_v    = in_valid;
      assign cur_rem  = in_val;
      assign cur_root = '0;
      assign cur_sb   = in_sb;
    end else begin : g_next
      assign cur_v    = v_r[s-1];
      assign cur_rem  = rem_r[s-1];
      assign cur_root = root_r[s-1];
      assign cur_sb   = sb_r[s-1];
    end

    assign trial = cur_root + BIT;
    assign take  = (cur_rem >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= take ? (cur_rem - trial) : cur_rem;
        root_r[s] <= take ? ((cur_root >> 1) + BIT) : (cur_root >> 1);
        sb_r[s]   <= cur_sb;
      end
    end
  end

  assign out_valid = v_r[R_W-1];
  assign out_root  = root_r[R_W-1][R_W-1:0];
  assign out_sb    = sb_r[R_W-1];

endmodule

`default_nettype wire

@@ design/cbop_checker.sv @@
// ----------------------------------------------------------------------------
// cbop_checker
// Port-level checks for the Bezier offset point unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "cubic_bezier_offset_points_unit_defines.svh"

module cbop_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  out_point_index,
  input logic [31:0] out_center_x,
  input logic [31:0] out_center_y,
  input logic [31:0] out_left_x,
  input logic [31:0] out_right_y,
  input logic        out_flat_tangent,
  input logic        out_last
);

  // A held result beat keeps its index and centre x.
  `CBOP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_point_index) && $stable(out_center_x), "result beat changed while stalled")

  // Taking a curve beat keeps the input closed while its points are issued.
  `CBOP_ASSERT_NXT(a_in_busy, clk, rst_n, in_valid && !in_stall, in_stall, "input not stalled after a curve beat")

  // With no tangent both offset points coincide with the curve point.
  `CBOP_ASSERT_IMP(a_flat_center, clk, rst_n, out_valid && out_flat_tangent, out_left_x == out_center_x && out_right_y == out_center_y, "flat offset differs from centre")

  // There is always at least one segment, so the first point is never last.
  `CBOP_ASSERT_IMP(a_last_index, clk, rst_n, out_valid && out_last, out_point_index != 6'd0, "last beat with index zero")

endmodule

bind cubic_bezier_offset_points_unit cbop_checker u_cbop_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the Bezier offset point unit against a built-in fixed point predictor.
// It applies directed curves, then random curves over several segment counts
// and offset distances. Both handshakes idle at random. The receiver holds off
// once for a long stretch.
// ----------------------------------------------------------------------------

module testbench;

  import cbop_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 150;

  typedef struct {
    logic signed [31:0] x[4];
    logic signed [31:0] y[4];
  } curve_t;

  typedef struct {
    logic [5:0]         idx;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic               flat;
    logic               last;
  } curve_point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SEGMENT_COUNT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_c[8] = '{default: '0};
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] out_point_index;
  logic signed [31:0] out_center_x, out_center_y, out_left_x, out_left_y;
  logic signed [31:0] out_right_x, out_right_y;
  logic out_flat_tangent, out_last;

  // Predictor copy of the two registers.
  logic [5:0]  seg_count = SEG_COUNT_RESET;
  logic [30:0] offset_dist = OFFSET_RESET;

  curve_point_t expected_points[$];
  int  error_count = 0;
  int  idle_cycles = 0;
  bit  steady = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_cnt = 0;

  always #5 clk = ~clk;

  cubic_bezier_offset_points_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_ctrl0_x(in_c[0]), .in_ctrl0_y(in_c[1]), .in_ctrl1_x(in_c[2]),
    .in_ctrl1_y(in_c[3]), .in_ctrl2_x(in_c[4]), .in_ctrl2_y(in_c[5]),
    .in_ctrl3_x(in_c[6]), .in_ctrl3_y(in_c[7]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_point_index(out_point_index),
    .out_center_x(out_center_x), .out_center_y(out_center_y),
    .out_left_x(out_left_x), .out_left_y(out_left_y),
    .out_right_x(out_right_x), .out_right_y(out_right_y),
    .out_flat_tangent(out_flat_tangent), .out_last(out_last)
  );

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Rounds to nearest, halves away from zero.
  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned q;
    q = (magnitude(num) + den / 2) / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Works out every point of one curve under the current register values.
  task automatic predict_curve_points(curve_t c);
    longint px[4], py[4], dx[3], dy[3];
    longint n, u, cx, cy, tx, ty, ox, oy, w0, w1, w2, w3;
    longint unsigned ax, ay, mx, len, d;
    curve_point_t p;
    for (int k = 0; k < 4; k++) begin
      px[k] = c.x[k];
      py[k] = c.y[k];
    end
    for (int k = 0; k < 3; k++) begin
      dx[k] = 3 * (px[k+1] - px[k]);
      dy[k] = 3 * (py[k+1] - py[k]);
    end
    n = seg_count;
    if (n < 1) n = 1;
    d = offset_dist;
    for (longint i = 0; i <= n; i++) begin
      u = n - i;
      if (i == 0) begin
        cx = px[0];
        cy = py[0];
      end else if (i == n) begin
        cx = px[3];
        cy = py[3];
      end else begin
        w0 = u * u * u;
        w1 = 3 * u * u * i;
        w2 = 3 * u * i * i;
        w3 = i * i * i;
        cx = round_div(w0 * px[0] + w1 * px[1] + w2 * px[2] + w3 * px[3], n * n * n);
        cy = round_div(w0 * py[0] + w1 * py[1] + w2 * py[2] + w3 * py[3], n * n * n);
      end
      tx = dx[0] * u * u + 2 * dx[1] * u * i + dx[2] * i * i;
      ty = dy[0] * u * u + 2 * dy[1] * u * i + dy[2] * i * i;
      ox = 0;
      oy = 0;
      p.flat = (tx == 0 && ty == 0);
      if (!p.flat) begin
        ax = magnitude(tx);
        ay = magnitude(ty);
        mx = ax > ay ? ax : ay;
        // Normalise so that the larger component lies in [2^30, 2^31).
        while (mx >= (64'd1 << 31)) begin
          ax >>= 1; ay >>= 1; mx >>= 1;
        end
        while (mx < (64'd1 << 30)) begin
          ax <<= 1; ay <<= 1; mx <<= 1;
        end
        len = int_sqrt(ax * ax + ay * ay);
        ox = (d * ax + len / 2) / len;
        oy = (d * ay + len / 2) / len;
        if (tx < 0) ox = -ox;
        if (ty < 0) oy = -oy;
      end
      p.idx  = i[5:0];
      p.cx   = clamp32(cx);
      p.cy   = clamp32(cy);
      p.lx   = clamp32(cx + oy);
      p.ly   = clamp32(cy - ox);
      p.rx   = clamp32(cx - oy);
      p.ry   = clamp32(cy + ox);
      p.last = (i == n);
      expected_points = {expected_points, p};
    end
  endtask

  // A degenerate curve at the origin: every point is zero and flat.
  task automatic expect_origin_points();
    int n;
    curve_point_t p;
    n = seg_count == 0 ? 1 : seg_count;
    for (int i = 0; i <= n; i++) begin
      p = '{idx: i[5:0], cx: 0, cy: 0, lx: 0, ly: 0, rx: 0, ry: 0,
            flat: 1'b1, last: (i == n)};
      expected_points = {expected_points, p};
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    curve_point_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected beat, index", out_point_index, -1);
      end else begin
        e = expected_points.pop_front();
        if (out_point_index !== e.idx) report_mismatch("point_index", out_point_index, e.idx);
        if (out_center_x !== e.cx) report_mismatch("center_x", out_center_x, e.cx);
        if (out_center_y !== e.cy) report_mismatch("center_y", out_center_y, e.cy);
        if (out_left_x !== e.lx) report_mismatch("left_x", out_left_x, e.lx);
        if (out_left_y !== e.ly) report_mismatch("left_y", out_left_y, e.ly);
        if (out_right_x !== e.rx) report_mismatch("right_x", out_right_x, e.rx);
        if (out_right_y !== e.ry) report_mismatch("right_y", out_right_y, e.ry);
        if (out_flat_tangent !== e.flat)
          report_mismatch("flat_tangent", out_flat_tangent, e.flat);
        if (out_last !== e.last) report_mismatch("last", out_last, e.last);
      end
    end
  end

  // Receiver stalls; one long hold-off lets the block back up to its input.
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_cnt  <= 400;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < 24);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] val);
    while (expected_points.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_SEGMENT_COUNT) seg_count = val[5:0];
    else offset_dist = val;
    @(posedge clk);
  endtask

  // Sends one curve beat; typed rows use hand-written expectations.
  task automatic send_curve(curve_t c, bit typed);
    while (!steady && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      in_c[2*k]   <= c.x[k];
      in_c[2*k+1] <= c.y[k];
    end
    do @(posedge clk); while (in_stall);
    if (typed) expect_origin_points();
    else predict_curve_points(c);
  endtask

  function automatic logic signed [31:0] random_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      1:       return $signed($urandom_range(0, 2000)) - 1000;
      2:       return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
      default: return $urandom();
    endcase
  endfunction

  function automatic curve_t random_curve();
    curve_t c;
    for (int k = 0; k < 4; k++) begin
      c.x[k] = random_coord();
      c.y[k] = random_coord();
    end
    // Coincident neighbours give a zero tangent at an end point.
    if ($urandom_range(0, 9) == 0) begin
      c.x[1] = c.x[0]; c.y[1] = c.y[0];
    end
    if ($urandom_range(0, 9) == 0) begin
      c.x[2] = c.x[3]; c.y[2] = c.y[3];
    end
    if ($urandom_range(0, 19) == 0) begin
      for (int k = 1; k < 4; k++) begin
        c.x[k] = c.x[0]; c.y[k] = c.y[0];
      end
    end
    return c;
  endfunction

  function automatic curve_t make_curve(longint x0, longint y0, longint x1, longint y1,
                                        longint x2, longint y2, longint x3, longint y3);
    curve_t c;
    c.x = '{x0[31:0], x1[31:0], x2[31:0], x3[31:0]};
    c.y = '{y0[31:0], y1[31:0], y2[31:0], y3[31:0]};
    return c;
  endfunction

  localparam longint MAXV = 2147483647;
  localparam longint MINV = -2147483648;

  curve_t stim_curve[$];
  bit     stim_typed[$];

  task automatic add_row(curve_t c, bit typed);
    stim_curve = {stim_curve, c};
    stim_typed = {stim_typed, typed};
  endtask

  initial begin
    int seg_plan[6];
    longint dist_plan[6];
    int count_plan[6];
    seg_plan   = '{1, 63, 0, 5, 17, 3};
    dist_plan  = '{0, 2147483647, 1, -1, -1, 65536};
    count_plan = '{30, 8, 30, 50, 30, 60};

    add_row(make_curve(0, 0, 0, 0, 0, 0, 0, 0), 1'b1);
    add_row(make_curve(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV), 1'b0);
    add_row(make_curve(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV), 1'b0);
    add_row(make_curve(MINV, MINV, MAXV, MINV, MINV, MAXV, MAXV, MAXV), 1'b0);
    add_row(make_curve(MAXV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MINV), 1'b0);
    add_row(make_curve(0, 0, 65536, 0, 131072, 0, 196608, 0), 1'b0);
    add_row(make_curve(0, 0, 0, -65536, 0, -131072, 0, -196608), 1'b0);
    add_row(make_curve(100, 100, 100, 100, 5000, -3000, 9000, 0), 1'b0);
    add_row(make_curve(0, 0, 7000, 9000, 20000, 20000, 20000, 20000), 1'b0);
    add_row(make_curve(MAXV, 0, MAXV, 0, MAXV, 0, MAXV, 0), 1'b0);
    add_row(make_curve(MAXV - 5, MAXV - 5, MAXV, MAXV - 9, MAXV, MAXV, MAXV - 1, MAXV),
            1'b0);
    add_row(make_curve(0, 0, 65536, 65536, -65536, 65536, 0, 0), 1'b0);
    add_row(make_curve(-1, -1, 1, 1, -1, 1, 1, -1), 1'b0);
    add_row(make_curve(MINV, MAXV, 0, 0, 0, 0, MAXV, MINV), 1'b0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_curve[r]) send_curve(stim_curve[r], stim_typed[r]);
    in_valid <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_SEGMENT_COUNT, 31'(seg_plan[ph]));
      write_reg(REG_OFFSET_DISTANCE,
                dist_plan[ph] < 0 ? 31'($urandom()) : dist_plan[ph][30:0]);
      steady   = (ph == 3);
      hold_req = (ph == 4);
      // The origin curve again, now under a new segment count.
      if (ph == 2) send_curve(make_curve(0, 0, 0, 0, 0, 0, 0, 0), 1'b1);
      for (int k = 0; k < count_plan[ph]; k++) send_curve(random_curve(), 1'b0);
      in_valid <= 1'b0;
    end

    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_points.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/cbop_pkg.sv
design/cbop_seq.sv
design/cbop_div.sv
design/cbop_isqrt.sv
design/cubic_bezier_offset_points_unit.sv
design/cbop_checker.sv
tb/testbench.sv
